FILE: rtl/base64_stream_encoder_assert.svh
//------------------------------------------------------------------------------
// Base64 stream encoder assertion macros
// Shared concurrent assertion forms. Each macro expects clk and rst_n in scope.
//------------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// The condition must never hold at a clock edge outside reset.
`define B64E_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// When the antecedent holds, the consequent must hold at the next clock edge.
`define B64E_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/b64e_pkg.sv
//------------------------------------------------------------------------------
// Base64 stream encoder package
// Item types, the command passed from front to back, and the alphabet map.
//------------------------------------------------------------------------------
package b64e_pkg;

    localparam logic [6:0] PAD_CHAR = 7'd61;
    localparam int unsigned CMD_SLOTS = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } b64e_byte_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last_char;
    } b64e_char_t;

    // One accepted byte turns into one to four characters. Each slot holds a
    // six-bit group or a pad mark; last_idx is the final slot in use.
    typedef struct packed {
        logic [1:0]                      last_idx;
        logic [CMD_SLOTS-1:0]            pad;
        logic [CMD_SLOTS-1:0][5:0]       grp;
        logic                            last;
    } b64e_cmd_t;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
    function automatic logic [6:0] b64e_char(input logic [5:0] grp);
        logic [6:0] val;
        logic [6:0] code;
        val = {1'b0, grp};
        priority if (grp < 6'd26)
        begin
            code = val + 7'd65;
        end
        else if (grp < 6'd52)
        begin
            code = val + 7'd71;
        end
        else if (grp < 6'd62)
        begin
            code = val - 7'd4;
        end
        else if (grp == 6'd62)
        begin
            code = 7'd43;
        end
        else
        begin
            code = 7'd47;
        end
        return code;
    endfunction

endpackage

FILE: rtl/base64_stream_encoder.sv
//------------------------------------------------------------------------------
// Base64 stream encoder
// Encodes a byte stream into standard-alphabet base64 characters with padding.
//------------------------------------------------------------------------------
// Usage: the byte channel (byte_valid, byte_stall, byte_item) takes one raw
// byte per item together with an end-of-message flag. The char channel
// (char_valid, char_stall, char_item) returns one ASCII character per item,
// with last_char set on the final character of an encoded message. An item
// moves on a rising edge where valid is high and stall is low.
// A byte yields one or two characters, and up to four on the final byte of a
// message, where the last group is zero-filled and '=' pads the output to a
// multiple of four characters. The front end builds one command per byte in
// the cycle it arrives and writes it into the command queue; the back end
// then loads the first character of that byte from the queue head into the
// output register. The back end sends one character per cycle while
// char_stall is low, which sets the rate: four characters per three bytes.
// byte_stall rises only when the command queue is full; a stalled receiver
// holds the current character and the queue absorbs further bytes until full.
// Reset clears the group phase, the queue and the output valid flag.
//------------------------------------------------------------------------------
module base64_stream_encoder
    import b64e_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  b64e_byte_t byte_item,
    output logic       char_valid,
    input  logic       char_stall,
    output b64e_char_t char_item
);

    // Command hand-off between the front end and the back end.
    logic      push;
    logic      pop;
    logic      full;
    logic      empty;
    b64e_cmd_t push_cmd;
    b64e_cmd_t head_cmd;

    // Front end: phase tracking and splitting of each byte into groups.
    b64e_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .full       (full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // Queue: lets the front keep taking bytes while the back is stalled.
    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (empty)
    );

    // Back end: alphabet mapping and the registered output stage.
    b64e_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_cmd   (head_cmd),
        .empty      (empty),
        .pop        (pop),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item)
    );

endmodule

FILE: rtl/b64e_front.sv
//------------------------------------------------------------------------------
// Base64 encoder front end
// Accepts bytes, tracks the three-byte group phase and builds one command.
//------------------------------------------------------------------------------
module b64e_front
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  b64e_byte_t byte_item,
    input  logic       full,
    output logic       push,
    output b64e_cmd_t  push_cmd
);

    typedef enum logic [1:0] {
        PHASE_FIRST,
        PHASE_SECOND,
        PHASE_THIRD
    } phase_t;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [3:0] leftover_reg;
    logic [3:0] leftover_next;

    logic [7:0] b;
    logic       eom;

    assign byte_stall = full;
    assign push       = byte_valid && !full;
    assign b          = byte_item.data_byte;
    assign eom        = byte_item.end_of_message;

    always_comb
    begin
        push_cmd      = '0;
        phase_next    = PHASE_FIRST;
        leftover_next = '0;
        unique case (phase_reg)
            PHASE_SECOND:
            begin
                push_cmd.grp[0] = {leftover_reg[1:0], b[7:4]};
                if (eom)
                begin
                    push_cmd.grp[1]  = {b[3:0], 2'b00};
                    push_cmd.pad[2]  = 1'b1;
                    push_cmd.last_idx = 2'd2;
                    push_cmd.last    = 1'b1;
                end
                else
                begin
                    leftover_next = b[3:0];
                    phase_next    = PHASE_THIRD;
                end
            end
            PHASE_THIRD:
            begin
                push_cmd.grp[0]   = {leftover_reg, b[7:6]};
                push_cmd.grp[1]   = b[5:0];
                push_cmd.last_idx = 2'd1;
                push_cmd.last     = eom;
            end
            default:
            begin
                // The unused fourth phase code behaves as the group start.
                push_cmd.grp[0] = b[7:2];
                if (eom)
                begin
                    push_cmd.grp[1]   = {b[1:0], 4'b0000};
                    push_cmd.pad[2]   = 1'b1;
                    push_cmd.pad[3]   = 1'b1;
                    push_cmd.last_idx = 2'd3;
                    push_cmd.last     = 1'b1;
                end
                else
                begin
                    leftover_next = {2'b00, b[1:0]};
                    phase_next    = PHASE_SECOND;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PHASE_FIRST;
            leftover_reg <= '0;
        end
        else if (push)
        begin
            phase_reg    <= phase_next;
            leftover_reg <= leftover_next;
        end
    end

endmodule

FILE: rtl/b64e_queue.sv
//------------------------------------------------------------------------------
// Base64 encoder command queue
// Small first-in first-out buffer of commands between front and back.
//------------------------------------------------------------------------------
`include "base64_stream_encoder_assert.svh"

module b64e_queue
    import b64e_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  b64e_cmd_t push_cmd,
    output logic      full,
    input  logic      pop,
    output b64e_cmd_t head_cmd,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    b64e_cmd_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    `B64E_NEVER(a_no_push_full, push && full, "command pushed into a full queue")
    `B64E_NEVER(a_no_pop_empty, pop && empty, "command popped from an empty queue")
    `B64E_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "bad count on push")
    `B64E_NEXT(a_count_down, pop && !push, count_reg == $past(count_reg) - 1'b1, "bad count on pop")

endmodule

FILE: rtl/b64e_back.sv
//------------------------------------------------------------------------------
// Base64 encoder back end
// Walks the head command one character a cycle, unless stalled, into the output register.
//------------------------------------------------------------------------------
module b64e_back
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  b64e_cmd_t  head_cmd,
    input  logic       empty,
    output logic       pop,
    output logic       char_valid,
    input  logic       char_stall,
    output b64e_char_t char_item
);

    logic       char_valid_reg;
    logic       char_valid_next;
    b64e_char_t char_item_reg;
    b64e_char_t char_item_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       load;
    logic       at_end;

    // The output register takes a new character when a command is queued and it is empty or drains.
    assign load   = !empty && (!char_valid_reg || !char_stall);
    assign at_end = (idx_reg == head_cmd.last_idx);
    assign pop    = load && at_end;

    always_comb
    begin
        char_item_next.out_char  = head_cmd.pad[idx_reg] ? PAD_CHAR
                                                         : b64e_char(head_cmd.grp[idx_reg]);
        char_item_next.last_char = head_cmd.last && at_end;
        idx_next                 = at_end ? 2'd0 : idx_reg + 2'd1;
        char_valid_next          = load || (char_valid_reg && char_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            char_valid_reg <= char_valid_next;
            if (load)
            begin
                idx_reg <= idx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_item_reg <= char_item_next;
        end
    end

    assign char_valid = char_valid_reg;
    assign char_item  = char_item_reg;

endmodule
